/* rtl/itehist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itehist_pkg;

   // bin counter, saturating
   localparam int CNT_W = 11;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // result field widths
   localparam int ENERGY_W = 6;
   localparam int FIELD_W  = 5;
   localparam int WEIGHT_W = 6;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
   localparam int RSP_DATA_W = 24;

   // request field widths that do not follow the row width
   localparam int ROT_W   = 4;
   localparam int DIV_W   = 6;
   localparam int WIDTH_W = 5;
   localparam int POP_W   = 32;

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_WIDTH  = 2'd0,
      CSR_CYCLIC     = 2'd1,
      CSR_FIELD_MODE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_WALK,
      BACK_DRAIN,
      BACK_SCAN,
      BACK_READ,
      BACK_DIV,
      BACK_EMIT
   } back_state_type;

   // per-item control fields worked out by the front end
   typedef struct packed {
      logic                row_not_mirror;
      logic                col_not_mirror;
      logic [ROT_W-1:0]    row_rotations;
      logic [ROT_W-1:0]    col_rotations;
      logic [ENERGY_W-1:0] h_energy;
      logic [FIELD_W-1:0]  field_index;
      logic [DIV_W-1:0]    divisor;
   } desc_ctl_type;

   typedef struct packed {
      logic                last;
      logic [WEIGHT_W-1:0] weight;
      logic [FIELD_W-1:0]  field_index;
      logic [ENERGY_W-1:0] energy_index;
   } rsp_item_type;

   // nibble counts first, then eight narrow adds
   function automatic logic [ENERGY_W-1:0] popcount(input logic [POP_W-1:0] v);
      logic [ENERGY_W-1:0] c;
      logic [2:0]          nib;
      c = '0;
      for (int i = 0; i < POP_W / 4; i++) begin
         nib = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
         c = c + ENERGY_W'(nib);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/itehist_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module itehist_front #(
   parameter int MAX_WIDTH = 16,
   parameter int REQ_W     = 48,
   parameter int DESC_W    = 2 * MAX_WIDTH + $bits(itehist_pkg::desc_ctl_type)
) (
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [REQ_W-1:0]                     req_tdata,
   input  wire logic [itehist_pkg::WIDTH_W-1:0]      n_eff,
   input  wire logic [MAX_WIDTH-1:0]                 spin_mask,
   input  wire logic                                 cyclic,
   input  wire logic                                 field_mode,
   input  wire logic                                 q_full,
   output logic                                      q_push,
   output logic [DESC_W-1:0]                         q_push_data
);

   localparam int MW = MAX_WIDTH;

   logic [MW-1:0]                      row;
   logic [MW-1:0]                      col;
   logic [MW-1:0]                      row_top;
   logic [MW-1:0]                      row_rot;
   logic [MW-1:0]                      bond_diff;
   logic [itehist_pkg::ENERGY_W-1:0]   row_pop;
   logic [itehist_pkg::DIV_W-1:0]      col_order;
   itehist_pkg::desc_ctl_type          ctl;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      row = req_tdata[MW-1:0] & spin_mask;
      col = req_tdata[2*MW-1:MW] & spin_mask;

      ctl.row_not_mirror = req_tdata[2*MW];
      ctl.col_not_mirror = req_tdata[2*MW+1];
      ctl.row_rotations  = req_tdata[2*MW+2 +: itehist_pkg::ROT_W];
      ctl.col_rotations  = req_tdata[2*MW+2+itehist_pkg::ROT_W +: itehist_pkg::ROT_W];

      // horizontal bonds: row against its left rotation
      row_top   = row >> (n_eff - itehist_pkg::WIDTH_W'(1));
      row_rot   = ({row[MW-2:0], 1'b0} & spin_mask) | MW'(row_top[0]);
      bond_diff = row ^ row_rot;
      if (!cyclic) begin
         bond_diff[0] = 1'b0;
      end
      ctl.h_energy = itehist_pkg::popcount(itehist_pkg::POP_W'(bond_diff));

      row_pop = itehist_pkg::popcount(itehist_pkg::POP_W'(row));
      ctl.field_index = field_mode ? (n_eff - itehist_pkg::FIELD_W'(row_pop)) : '0;

      col_order = itehist_pkg::DIV_W'(ctl.col_rotations) + itehist_pkg::DIV_W'(1);
      if (cyclic) begin
         ctl.divisor = ctl.col_not_mirror ? (col_order << 1) : col_order;
      end else begin
         ctl.divisor = ctl.col_not_mirror ? itehist_pkg::DIV_W'(2) : itehist_pkg::DIV_W'(1);
      end

      q_push_data = {row, col, ctl};
   end

endmodule

`default_nettype wire

/* rtl/itehist_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module itehist_queue #(
   parameter int DATA_W = 74
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output logic [DATA_W-1:0]      head_data
);

   // two entries
   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/itehist_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module itehist_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [itehist_pkg::CNT_W-1:0]    dividend,
   input  wire logic [itehist_pkg::DIV_W-1:0]    divisor,
   output logic                                  busy,
   output logic [itehist_pkg::CNT_W-1:0]         quotient
);

   localparam int CW     = itehist_pkg::CNT_W;
   localparam int DW     = itehist_pkg::DIV_W;
   localparam int STEP_W = $clog2(CW + 1);

   logic              busy_ff;
   logic              busy_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [CW-1:0]     quot_ff;
   logic [CW-1:0]     quot_in;
   logic [DW:0]       rem_ff;
   logic [DW:0]       rem_in;
   logic [DW-1:0]     dsor_ff;
   logic [DW-1:0]     dsor_in;
   logic [DW:0]       rem_sh;
   logic              fits;

   assign busy     = busy_ff;
   assign quotient = quot_ff;

   // restoring division, one quotient bit a cycle
   always_comb begin
      rem_sh  = {rem_ff[DW-1:0], quot_ff[CW-1]};
      fits    = (rem_sh >= {1'b0, dsor_ff});
      busy_in = busy_ff;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = dividend;
         rem_in  = '0;
         dsor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? (rem_sh - {1'b0, dsor_ff}) : rem_sh;
         quot_in = {quot_ff[CW-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(CW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

endmodule

`default_nettype wire

/* rtl/itehist_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module itehist_back #(
   parameter int MAX_WIDTH = 16,
   parameter int DESC_W    = 2 * MAX_WIDTH + $bits(itehist_pkg::desc_ctl_type)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [itehist_pkg::WIDTH_W-1:0]  n_eff,
   input  wire logic [MAX_WIDTH-1:0]             spin_mask,
   input  wire logic                             cyclic,
   input  wire logic                             head_valid,
   input  wire logic [DESC_W-1:0]                head_data,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output itehist_pkg::rsp_item_type             rsp_item
);

   localparam int MW       = MAX_WIDTH;
   localparam int NUM_BINS = 2 * MAX_WIDTH + 1;
   localparam int BIN_W    = $clog2(NUM_BINS);
   localparam int CTL_W    = $bits(itehist_pkg::desc_ctl_type);
   localparam int CW       = itehist_pkg::CNT_W;
   localparam int WIDTH_W  = itehist_pkg::WIDTH_W;
   localparam int ROT_W    = itehist_pkg::ROT_W;
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

   function automatic logic [MW-1:0] rotl(input logic [MW-1:0] v,
                                          input logic [WIDTH_W-1:0] n,
                                          input logic [MW-1:0] m);
      logic [MW-1:0] top;
      top = v >> (n - WIDTH_W'(1));
      return ({v[MW-2:0], 1'b0} & m) | MW'(top[0]);
   endfunction

   function automatic logic [MW-1:0] mirror(input logic [MW-1:0] v,
                                            input logic [WIDTH_W-1:0] n);
      logic [MW-1:0] rev;
      for (int i = 0; i < MW; i++) begin
         rev[i] = v[MW-1-i];
      end
      return rev >> (WIDTH_W'(MW) - n);
   endfunction

   itehist_pkg::desc_ctl_type   ctl;
   logic [MW-1:0]               head_row;
   logic [MW-1:0]               head_col;

   itehist_pkg::back_state_type state_ff;
   itehist_pkg::back_state_type state_in;

   // orbit walker
   logic [MW-1:0]    nn_ff;
   logic [MW-1:0]    nn_in;
   logic [MW-1:0]    mm_ff;
   logic [MW-1:0]    mm_in;
   logic             p_ff;
   logic             p_in;
   logic             q_ff;
   logic             q_in;
   logic [ROT_W-1:0] r_ff;
   logic [ROT_W-1:0] r_in;
   logic [ROT_W-1:0] s_ff;
   logic [ROT_W-1:0] s_in;
   logic [MW-1:0]    nn_rot;
   logic [MW-1:0]    mm_rot;
   logic             walk_done;
   logic [itehist_pkg::ENERGY_W-1:0] visit_sum;

   // bin counters: memory plus valid bits
   logic [CW-1:0]       count_mem [NUM_BINS];
   logic [CW-1:0]       rd_data_ff;
   logic [BIN_W-1:0]    rd_addr;
   logic [NUM_BINS-1:0] bin_valid_ff;
   logic [NUM_BINS-1:0] bin_valid_in;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [BIN_W-1:0]    s1_idx_ff;
   logic [BIN_W-1:0]    s1_idx_in;
   logic                wr_valid_ff;
   logic [BIN_W-1:0]    wr_idx_ff;
   logic [CW-1:0]       wr_data_ff;
   logic [CW-1:0]       old_cnt;
   logic [CW-1:0]       new_cnt;

   // scan and emit
   logic [BIN_W-1:0]    bin_ff;
   logic [BIN_W-1:0]    bin_in;
   logic [NUM_BINS-1:0] clear_mask;
   logic                clear_bin;
   logic                none_left;
   logic                div_start;
   logic                div_busy;
   logic [CW-1:0]       div_quot;
   logic                load_rsp;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   itehist_pkg::rsp_item_type rsp_item_ff;
   itehist_pkg::rsp_item_type rsp_item_in;

   assign ctl      = itehist_pkg::desc_ctl_type'(head_data[CTL_W-1:0]);
   assign head_col = head_data[CTL_W +: MW];
   assign head_row = head_data[CTL_W+MW +: MW];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   itehist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (ctl.divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // next position on the orbit
   always_comb begin
      nn_rot    = rotl(nn_ff, n_eff, spin_mask);
      mm_rot    = rotl(mm_ff, n_eff, spin_mask);
      visit_sum = itehist_pkg::popcount(itehist_pkg::POP_W'(nn_ff ^ mm_ff)) + ctl.h_energy;
   end

   // count update, forwarding the write of the cycle before
   always_comb begin
      if (wr_valid_ff && (wr_idx_ff == s1_idx_ff)) begin
         old_cnt = wr_data_ff;
      end else if (bin_valid_ff[s1_idx_ff]) begin
         old_cnt = rd_data_ff;
      end else begin
         old_cnt = '0;
      end
      new_cnt = (old_cnt == itehist_pkg::CNT_MAX) ? old_cnt : (old_cnt + CW'(1));
   end

   always_comb begin
      clear_mask = NUM_BINS'(1) << bin_ff;
      none_left  = ((bin_valid_ff & ~clear_mask) == '0);
   end

   always_comb begin
      state_in    = state_ff;
      nn_in       = nn_ff;
      mm_in       = mm_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      s_in        = s_ff;
      walk_done   = 1'b0;
      s1_valid_in = 1'b0;
      s1_idx_in   = visit_sum[BIN_W-1:0];
      rd_addr     = bin_ff;
      bin_in      = bin_ff;
      clear_bin   = 1'b0;
      div_start   = 1'b0;
      load_rsp    = 1'b0;
      pop         = 1'b0;
      rsp_item_in = rsp_item_ff;

      unique case (state_ff)
         itehist_pkg::BACK_IDLE: begin
            if (head_valid) begin
               nn_in    = head_row;
               mm_in    = head_col;
               p_in     = 1'b0;
               q_in     = 1'b0;
               r_in     = '0;
               s_in     = '0;
               state_in = itehist_pkg::BACK_WALK;
            end
         end
         itehist_pkg::BACK_WALK: begin
            s1_valid_in = 1'b1;
            rd_addr     = visit_sum[BIN_W-1:0];
            if (cyclic) begin
               mm_in = mm_rot;
               s_in  = s_ff + ROT_W'(1);
               if (s_ff == ctl.col_rotations) begin
                  s_in  = '0;
                  nn_in = nn_rot;
                  r_in  = r_ff + ROT_W'(1);
                  if (r_ff == ctl.row_rotations) begin
                     r_in  = '0;
                     mm_in = mirror(mm_rot, n_eff);
                     q_in  = ~q_ff;
                     if (q_ff == ctl.col_not_mirror) begin
                        q_in  = 1'b0;
                        nn_in = mirror(nn_rot, n_eff);
                        p_in  = ~p_ff;
                        walk_done = (p_ff == ctl.row_not_mirror);
                     end
                  end
               end
            end else begin
               mm_in = mirror(mm_ff, n_eff);
               q_in  = ~q_ff;
               if (q_ff == ctl.col_not_mirror) begin
                  q_in  = 1'b0;
                  mm_in = head_col;
                  nn_in = mirror(nn_ff, n_eff);
                  p_in  = ~p_ff;
                  walk_done = (p_ff == ctl.row_not_mirror);
               end
            end
            if (walk_done) begin
               state_in = itehist_pkg::BACK_DRAIN;
            end
         end
         itehist_pkg::BACK_DRAIN: begin
            // last count write lands this cycle
            bin_in   = '0;
            state_in = itehist_pkg::BACK_SCAN;
         end
         itehist_pkg::BACK_SCAN: begin
            if (bin_valid_ff[bin_ff]) begin
               state_in = itehist_pkg::BACK_READ;
            end else if (bin_ff == LAST_BIN) begin
               pop      = 1'b1;
               state_in = itehist_pkg::BACK_IDLE;
            end else begin
               bin_in = bin_ff + BIN_W'(1);
            end
         end
         itehist_pkg::BACK_READ: begin
            div_start = 1'b1;
            state_in  = itehist_pkg::BACK_DIV;
         end
         itehist_pkg::BACK_DIV: begin
            if (!div_busy) begin
               state_in = itehist_pkg::BACK_EMIT;
            end
         end
         itehist_pkg::BACK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp                 = 1'b1;
               clear_bin                = 1'b1;
               rsp_item_in.energy_index = itehist_pkg::ENERGY_W'(bin_ff);
               rsp_item_in.field_index  = ctl.field_index;
               rsp_item_in.weight       = (div_quot > CW'(itehist_pkg::WEIGHT_MAX))
                                          ? itehist_pkg::WEIGHT_MAX
                                          : div_quot[itehist_pkg::WEIGHT_W-1:0];
               rsp_item_in.last         = none_left;
               if (none_left) begin
                  pop      = 1'b1;
                  state_in = itehist_pkg::BACK_IDLE;
               end else begin
                  bin_in   = bin_ff + BIN_W'(1);
                  state_in = itehist_pkg::BACK_SCAN;
               end
            end
         end
         default: begin
            state_in = itehist_pkg::BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      bin_valid_in = bin_valid_ff;
      if (s1_valid_ff) begin
         bin_valid_in = bin_valid_in | (NUM_BINS'(1) << s1_idx_ff);
      end
      if (clear_bin) begin
         bin_valid_in = bin_valid_in & ~clear_mask;
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itehist_pkg::BACK_IDLE;
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         bin_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         wr_valid_ff  <= s1_valid_ff;
         bin_valid_ff <= bin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nn_ff       <= nn_in;
      mm_ff       <= mm_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      s_ff        <= s_in;
      s1_idx_ff   <= s1_idx_in;
      wr_idx_ff   <= s1_idx_ff;
      wr_data_ff  <= new_cnt;
      bin_ff      <= bin_in;
      rsp_item_ff <= rsp_item_in;
   end

   // bin count memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         count_mem[s1_idx_ff] <= new_cnt;
      end
      rd_data_ff <= count_mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/ising_transfer_element_histogram.sv */
// per item: an orbit walk of V visits (V = (1+rnm)(1+cnm) in free mode,
//   times (row_rotations+1)(col_rotations+1) in cyclic mode), a scan of the bins, and a
//   serial divide and emit per nonzero bin; the walk is bounded by the one-visit-a-cycle bin
//   memory port; one item is finished before the next starts, up to two items wait in queue
// reset: synchronous, clears config to row_width 4, free boundary, no field index, and
//   clears all bin valid bits at once (no memory sweep)
`timescale 1ns / 1ps
`default_nettype none

module ising_transfer_element_histogram #(
   parameter int MAX_WIDTH = 16,
   localparam int REQ_W    = ((2 * MAX_WIDTH + 10 + 7) / 8) * 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   // request item
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // row_spins, col_spins, row_not_mirror, col_not_mirror, row_rotations,
   // col_rotations, zero pad
   input  wire logic [REQ_W-1:0]                       req_tdata,

   // result item
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // energy_index, field_index, weight, zero pad
   output logic [itehist_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                        rsp_tlast,

   // configuration writes
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [itehist_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [itehist_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DESC_W  = 2 * MAX_WIDTH + $bits(itehist_pkg::desc_ctl_type);
   localparam int WIDTH_W = itehist_pkg::WIDTH_W;

   // config registers
   logic [WIDTH_W-1:0]   row_width_ff;
   logic [WIDTH_W-1:0]   row_width_in;
   logic                 cyclic_ff;
   logic                 cyclic_in;
   logic                 field_mode_ff;
   logic                 field_mode_in;

   // row width clamped into 1..MAX_WIDTH and its bit mask
   logic [WIDTH_W-1:0]   n_eff;
   logic [MAX_WIDTH-1:0] spin_mask;

   // front to queue to back
   logic                 q_full;
   logic                 q_push;
   logic [DESC_W-1:0]    q_push_data;
   logic                 q_pop;
   logic                 q_head_valid;
   logic [DESC_W-1:0]    q_head_data;

   itehist_pkg::rsp_item_type rsp_item;

   // config writes always taken
   assign csr_ready = 1'b1;

   always_comb begin
      row_width_in  = row_width_ff;
      cyclic_in     = cyclic_ff;
      field_mode_in = field_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            itehist_pkg::CSR_ROW_WIDTH:  row_width_in  = csr_wdata[WIDTH_W-1:0];
            itehist_pkg::CSR_CYCLIC:     cyclic_in     = csr_wdata[0];
            itehist_pkg::CSR_FIELD_MODE: field_mode_in = csr_wdata[0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= WIDTH_W'(4);
         cyclic_ff     <= 1'b0;
         field_mode_ff <= 1'b0;
      end else begin
         row_width_ff  <= row_width_in;
         cyclic_ff     <= cyclic_in;
         field_mode_ff <= field_mode_in;
      end
   end

   // zero width acts as one, anything above the maximum as the maximum
   always_comb begin
      if (row_width_ff == '0) begin
         n_eff = WIDTH_W'(1);
      end else if (row_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         n_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         n_eff = row_width_ff;
      end
      for (int i = 0; i < MAX_WIDTH; i++) begin
         spin_mask[i] = (WIDTH_W'(i) < n_eff);
      end
   end

   // front end: masks spins, works out bond energy, field index and divisor
   itehist_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .REQ_W     (REQ_W),
      .DESC_W    (DESC_W)
   ) u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .n_eff       (n_eff),
      .spin_mask   (spin_mask),
      .cyclic      (cyclic_ff),
      .field_mode  (field_mode_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // two-entry queue decouples intake from the orbit walk
   itehist_queue #(
      .DATA_W (DESC_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // back end: orbit walk into bin memory, then scan, divide and emit
   itehist_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .DESC_W    (DESC_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .n_eff      (n_eff),
      .spin_mask  (spin_mask),
      .cyclic     (cyclic_ff),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = itehist_pkg::RSP_DATA_W'({rsp_item.weight, rsp_item.field_index,
                                               rsp_item.energy_index});
   assign rsp_tlast = rsp_item.last;

endmodule

`default_nettype wire

/* rtl/itehist_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module itehist_checker #(
   parameter int MAX_WIDTH = 16
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_tvalid,
   input wire logic                                  rsp_tready,
   input wire logic [itehist_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                                  rsp_tlast
);

   localparam int EW = itehist_pkg::ENERGY_W;
   localparam int FW = itehist_pkg::FIELD_W;

   logic [EW-1:0] energy;
   logic [FW-1:0] field;
   logic [EW-1:0] prev_energy_ff;
   logic          in_frame_ff;

   assign energy = rsp_tdata[EW-1:0];
   assign field  = rsp_tdata[EW +: FW];

   // track whether a frame is open; the bin of the last taken item is kept below
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         in_frame_ff <= !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         prev_energy_ff <= energy;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (energy <= EW'(2 * MAX_WIDTH)) && (field <= FW'(MAX_WIDTH)))
      else $error("energy or field index out of range");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && in_frame_ff |-> energy > prev_energy_ff)
      else $error("bins not in ascending order within a frame");

endmodule

bind ising_transfer_element_histogram itehist_checker #(
   .MAX_WIDTH (MAX_WIDTH)
) u_itehist_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
